/* sv/lmsd_pkg.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// LED matrix serial driver package
// Request codes, result field constants and the controller/datapath bundles.
// -----------------------------------------------------------------------------
package lmsd_pkg;

	typedef enum logic [1:0] {
		REQ_SET_PIXEL   = 2'd0,
		REQ_SEND_COLUMN = 2'd1,
		REQ_INIT        = 2'd2,
		REQ_OPEN_LINE   = 2'd3
	} req_t;

	localparam logic [3:0] WB_NONE = 4'd0;
	localparam logic [3:0] WB_GAIN = 4'd6;
	localparam logic [3:0] WB_DATA = 4'd8;

	localparam logic [5:0] GAIN_RESET = 6'd63;
	localparam logic [7:0] LINE_MAX   = 8'd7;
	localparam int         PIX_BITS   = 24;

	typedef enum logic [1:0] {
		COL_BLUE  = 2'd0,
		COL_GREEN = 2'd1,
		COL_RED   = 2'd2
	} color_t;

	typedef struct packed {
		logic clr_step;
		logic wr_pixel;
		logic lines_update;
		logic init_start;
		logic col_capture;
		logic single_load;
		logic gain_load;
		logic rd_issue;
		logic byte_load;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic gain_last;
		logic row_last;
		logic color_last;
		logic out_free;
	} stat_t;

endpackage

/* sv/lmsd_if.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// LED matrix serial driver channels
// Request and result channels with valid/ready handshakes.
// -----------------------------------------------------------------------------
interface lmsd_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] req_type;
	logic [2:0] column;
	logic [2:0] row;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic [7:0] line_code;

	modport source (output valid, req_type, column, row, red, green, blue, line_code,
		input ready);
	modport sink (input valid, req_type, column, row, red, green, blue, line_code,
		output ready);
endinterface

interface lmsd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] shift_word;
	logic [3:0] word_bits;
	logic       bank_select;
	logic       latch_pulse;
	logic [7:0] line_enable;
	logic       last;

	modport source (output valid, shift_word, word_bits, bank_select, latch_pulse,
		line_enable, last, input ready);
	modport sink (input valid, shift_word, word_bits, bank_select, latch_pulse,
		line_enable, last, output ready);
endinterface

/* sv/lmsd_ram.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// -----------------------------------------------------------------------------
module lmsd_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

/* sv/lmsd_ctrl.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// LED matrix serial driver controller
// Sequences the clearing pass, request intake and the result runs.
// -----------------------------------------------------------------------------
module lmsd_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic [1:0]      in_req_type,
	output logic            in_ready,
	input  lmsd_pkg::stat_t stat,
	output lmsd_pkg::cmd_t  cmd
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SINGLE,
		ST_GAIN,
		ST_READ,
		ST_BYTE
	} state_t;

	state_t state_q;
	logic   fire;

	assign in_ready = (state_q == ST_IDLE);
	assign fire     = in_ready && in_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					if (stat.clr_last) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (in_valid) begin
						case (in_req_type)
							lmsd_pkg::REQ_INIT:        state_q <= ST_GAIN;
							lmsd_pkg::REQ_SEND_COLUMN: state_q <= ST_READ;
							default:                   state_q <= ST_SINGLE;
						endcase
					end
				end
				ST_SINGLE: begin
					if (stat.out_free) state_q <= ST_IDLE;
				end
				ST_GAIN: begin
					if (stat.out_free && stat.gain_last) state_q <= ST_IDLE;
				end
				ST_READ: begin
					state_q <= ST_BYTE;
				end
				ST_BYTE: begin
					if (stat.out_free && stat.color_last) begin
						state_q <= stat.row_last ? ST_IDLE : ST_READ;
					end
				end
				default: state_q <= ST_CLEAR;
			endcase
		end
	end

	always_comb begin
		cmd              = '0;
		cmd.clr_step     = (state_q == ST_CLEAR);
		cmd.wr_pixel     = fire && (in_req_type == lmsd_pkg::REQ_SET_PIXEL);
		cmd.lines_update = fire && (in_req_type == lmsd_pkg::REQ_OPEN_LINE);
		cmd.init_start   = fire && (in_req_type == lmsd_pkg::REQ_INIT);
		cmd.col_capture  = fire && (in_req_type == lmsd_pkg::REQ_SEND_COLUMN);
		cmd.single_load  = (state_q == ST_SINGLE) && stat.out_free;
		cmd.gain_load    = (state_q == ST_GAIN) && stat.out_free;
		cmd.rd_issue     = (state_q == ST_READ);
		cmd.byte_load    = (state_q == ST_BYTE) && stat.out_free;
	end

endmodule

/* sv/lmsd_datapath.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// LED matrix serial driver datapath
// Pixel store, line enables, bank flag, counters and the result register.
// -----------------------------------------------------------------------------
module lmsd_datapath #(
	parameter int GRID_SIZE  = 8,
	parameter int GAIN_WORDS = 24
) (
	input  logic            clk,
	input  logic            arst_n,
	input  lmsd_pkg::cmd_t  cmd,
	output lmsd_pkg::stat_t stat,
	input  logic [2:0]      in_column,
	input  logic [2:0]      in_row,
	input  logic [7:0]      in_red,
	input  logic [7:0]      in_green,
	input  logic [7:0]      in_blue,
	input  logic [7:0]      in_line_code,
	input  logic            cfg_we,
	input  logic [5:0]      cfg_wdata,
	input  logic            out_ready,
	output logic            out_valid,
	output logic [7:0]      out_shift_word,
	output logic [3:0]      out_word_bits,
	output logic            out_bank_select,
	output logic            out_latch_pulse,
	output logic [7:0]      out_line_enable,
	output logic            out_last
);

	localparam int CW    = $clog2(GRID_SIZE);
	localparam int DEPTH = GRID_SIZE * GRID_SIZE;
	localparam int AW    = $clog2(DEPTH);
	localparam int GW    = (GAIN_WORDS > 1) ? $clog2(GAIN_WORDS) : 1;

	function automatic logic [CW-1:0] wrap_idx(input logic [2:0] x);
		logic [5:0] v;
		v = {3'b000, x};
		for (int i = 0; i < 3; i++) begin
			if (v >= 6'(GRID_SIZE)) v = v - 6'(GRID_SIZE);
		end
		return CW'(v);
	endfunction

	function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] c,
		input logic [CW-1:0] r);
		return AW'(AW'(c) * AW'(GRID_SIZE) + AW'(r));
	endfunction

	logic [5:0]    gain_val_q;
	logic [7:0]    lines_q;
	logic          bank_q;
	logic [AW-1:0] clr_q;
	logic [GW-1:0] gain_cnt_q;
	logic [CW-1:0] col_q;
	logic [CW-1:0] row_q;
	logic [1:0]    color_q;

	logic          valid_q;
	logic [7:0]    word_q;
	logic [3:0]    bits_q;
	logic          bank_o_q;
	logic          latch_q;
	logic [7:0]    lines_o_q;
	logic          last_q;

	logic                          wr_en;
	logic [AW-1:0]                 wr_addr;
	logic [lmsd_pkg::PIX_BITS-1:0] wr_data;
	logic [lmsd_pkg::PIX_BITS-1:0] rd_data;
	logic [7:0]                    pix_byte;
	logic                          load;

	assign stat.clr_last   = (clr_q == AW'(DEPTH - 1));
	assign stat.gain_last  = (gain_cnt_q == GW'(GAIN_WORDS - 1));
	assign stat.row_last   = (row_q == CW'(GRID_SIZE - 1));
	assign stat.color_last = (color_q == lmsd_pkg::COL_RED);
	assign stat.out_free   = !valid_q || out_ready;

	assign wr_en   = cmd.clr_step || cmd.wr_pixel;
	assign wr_addr = cmd.clr_step ? clr_q : cell_addr(wrap_idx(in_column), wrap_idx(in_row));
	assign wr_data = cmd.clr_step ? '0 : {in_red, in_green, in_blue};

	lmsd_ram #(
		.WIDTH(lmsd_pkg::PIX_BITS),
		.DEPTH(DEPTH)
	) u_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (cmd.rd_issue),
		.rd_addr(cell_addr(col_q, row_q)),
		.rd_data(rd_data)
	);

	always_comb begin
		case (color_q)
			lmsd_pkg::COL_BLUE:  pix_byte = rd_data[7:0];
			lmsd_pkg::COL_GREEN: pix_byte = rd_data[15:8];
			default:             pix_byte = rd_data[23:16];
		endcase
	end

	assign load = cmd.single_load || cmd.gain_load || cmd.byte_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_val_q <= lmsd_pkg::GAIN_RESET;
			lines_q    <= '0;
			bank_q     <= 1'b0;
			clr_q      <= '0;
			gain_cnt_q <= '0;
			col_q      <= '0;
			row_q      <= '0;
			color_q    <= lmsd_pkg::COL_BLUE;
			valid_q    <= 1'b0;
		end else begin
			if (cfg_we) gain_val_q <= cfg_wdata;
			if (cmd.clr_step) clr_q <= clr_q + AW'(1);
			if (cmd.lines_update) begin
				if (in_line_code > lmsd_pkg::LINE_MAX) begin
					lines_q <= '0;
				end else begin
					lines_q <= lines_q | (8'b1 << in_line_code[2:0]);
				end
			end
			if (cmd.init_start) begin
				lines_q    <= '0;
				bank_q     <= 1'b0;
				gain_cnt_q <= '0;
			end
			if (cmd.gain_load) begin
				gain_cnt_q <= gain_cnt_q + GW'(1);
				if (stat.gain_last) bank_q <= 1'b1;
			end
			if (cmd.col_capture) begin
				col_q   <= wrap_idx(in_column);
				row_q   <= '0;
				color_q <= lmsd_pkg::COL_BLUE;
			end
			if (cmd.byte_load) begin
				if (stat.color_last) begin
					color_q <= lmsd_pkg::COL_BLUE;
					row_q   <= row_q + CW'(1);
				end else begin
					color_q <= color_q + 2'd1;
				end
			end
			if (load) begin
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.single_load) begin
			word_q    <= '0;
			bits_q    <= lmsd_pkg::WB_NONE;
			bank_o_q  <= bank_q;
			latch_q   <= 1'b0;
			lines_o_q <= lines_q;
			last_q    <= 1'b1;
		end else if (cmd.gain_load) begin
			word_q    <= {2'b00, gain_val_q};
			bits_q    <= lmsd_pkg::WB_GAIN;
			bank_o_q  <= stat.gain_last;
			latch_q   <= 1'b0;
			lines_o_q <= lines_q;
			last_q    <= stat.gain_last;
		end else if (cmd.byte_load) begin
			word_q    <= pix_byte;
			bits_q    <= lmsd_pkg::WB_DATA;
			bank_o_q  <= bank_q;
			latch_q   <= stat.row_last && stat.color_last;
			lines_o_q <= lines_q;
			last_q    <= stat.row_last && stat.color_last;
		end
	end

	assign out_valid       = valid_q;
	assign out_shift_word  = word_q;
	assign out_word_bits   = bits_q;
	assign out_bank_select = bank_o_q;
	assign out_latch_pulse = latch_q;
	assign out_line_enable = lines_o_q;
	assign out_last        = last_q;

endmodule

/* sv/led_matrix_serial_driver.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// LED matrix serial driver
// Pixel store and shift-word sequencing for an RGB LED matrix shift register.
//
//   channel   direction  payload
//   in_ch     sink       req_type, column, row, red, green, blue, line_code
//   out_ch    source     shift_word, word_bits, bank_select, latch_pulse,
//                        line_enable, last
//   cfg       write      cfg_we, cfg_wdata (gain value)
//
// Set pixel and open line each send one word with no shift bits; init sends
// GAIN_WORDS gain words. Send column does one pixel store read per row, then
// three byte transfers. After reset a clearing pass over all GRID_SIZE *
// GRID_SIZE pixel store cells runs before the first request is taken. A
// stalled result holds the sequence in place.
// -----------------------------------------------------------------------------
module led_matrix_serial_driver #(
	parameter int GRID_SIZE  = 8,
	parameter int GAIN_WORDS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	lmsd_in_if.sink     in_ch,
	lmsd_out_if.source  out_ch,
	input  logic        cfg_we,
	input  logic [5:0]  cfg_wdata
);

	lmsd_pkg::cmd_t  cmd;
	lmsd_pkg::stat_t stat;

	lmsd_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_ch.valid),
		.in_req_type(in_ch.req_type),
		.in_ready   (in_ch.ready),
		.stat       (stat),
		.cmd        (cmd)
	);

	lmsd_datapath #(
		.GRID_SIZE (GRID_SIZE),
		.GAIN_WORDS(GAIN_WORDS)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.in_column      (in_ch.column),
		.in_row         (in_ch.row),
		.in_red         (in_ch.red),
		.in_green       (in_ch.green),
		.in_blue        (in_ch.blue),
		.in_line_code   (in_ch.line_code),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.out_ready      (out_ch.ready),
		.out_valid      (out_ch.valid),
		.out_shift_word (out_ch.shift_word),
		.out_word_bits  (out_ch.word_bits),
		.out_bank_select(out_ch.bank_select),
		.out_latch_pulse(out_ch.latch_pulse),
		.out_line_enable(out_ch.line_enable),
		.out_last       (out_ch.last)
	);

	a_send_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.valid && in_ch.ready && in_ch.req_type == lmsd_pkg::REQ_SEND_COLUMN
		|=> !in_ch.ready)
		else $error("request taken while a column send is under way");

	a_latch_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.latch_pulse
		|-> out_ch.last && out_ch.word_bits == lmsd_pkg::WB_DATA)
		else $error("latch pulse outside the final data word");

	a_gain_bank: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.word_bits == lmsd_pkg::WB_GAIN
		|-> out_ch.bank_select == out_ch.last && out_ch.line_enable == 8'd0)
		else $error("gain word with wrong bank select or line enables");

	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr_step |-> !in_ch.ready && !out_ch.valid)
		else $error("traffic during the clearing pass");

endmodule
